FILE: src/jhmi_pkg.sv
// Shared request codes, status codes and controller/datapath handshake structs.
`timescale 1ns / 1ps
package jhmi_pkg;

  typedef enum logic [1:0] {
    REQ_COUNT  = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic clr_start;
    logic clr_step;
    logic cnt_wr;
    logic scan_start;
    logic scan_next;
    logic log_start;
    logic log_tot;
    logic mul;
    logic acc;
    logic ls_take;
    logic div_start;
    logic div_sel;
    logic take_q0;
    logic take_hc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic range_ok;
    logic sat;
    logic empty;
    logic clr_last;
    logic scan_last;
    logic scan_zero;
    logic log_done;
    logic div_done;
  } stat_t;

endpackage

FILE: src/joint_histogram_mutual_information_core.sv
// Top level: configuration registers, controller and datapath of the histogram estimator.
`timescale 1ns / 1ps
// The block takes one request at a time. A count request steps through accept, decode,
// read-modify-write of the pair, row and column memories (skipped when the sample is out of
// range or the total is saturated), and result. A clear request sweeps the memories one entry
// per cycle; the same clearing pass runs after reset, before the first request is accepted.
// A report scans NUM_X+NUM_Y+NUM_X*NUM_Y entries: a zero entry is skipped, a nonzero entry
// passes through the serial log unit and multiplier, and two restoring divisions finish it.
// A finished result is held in the output register until it is taken.
module joint_histogram_mutual_information_core #(
  parameter int NUM_X      = 16,
  parameter int NUM_Y      = 16,
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [3:0]         sample_x_i,
  input  logic [3:0]         sample_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [23:0]        entropy_x_o,
  output logic [23:0]        cond_entropy_o,
  output logic signed [24:0] mutual_info_o,
  output logic [23:0]        sample_total_o
);
  import jhmi_pkg::*;

  localparam logic       REG_X_SYMBOLS = 1'b0;
  localparam logic       REG_Y_SYMBOLS = 1'b1;
  localparam logic [4:0] SYMBOLS_RESET = 5'd16;

  logic [4:0] x_symbols_q, y_symbols_q;
  logic       wr_en;
  cmd_t       cmd;
  stat_t      stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = {27'd0, (paddr[2] == REG_Y_SYMBOLS) ? y_symbols_q : x_symbols_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_symbols_q <= SYMBOLS_RESET;
      y_symbols_q <= SYMBOLS_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_X_SYMBOLS) x_symbols_q <= pwdata[4:0];
      else y_symbols_q <= pwdata[4:0];
    end
  end

  jhmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  jhmi_datapath #(
    .NUM_X      (NUM_X),
    .NUM_Y      (NUM_Y),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_type_i),
    .sample_x_i     (sample_x_i),
    .sample_y_i     (sample_y_i),
    .x_symbols_i    (x_symbols_q),
    .y_symbols_i    (y_symbols_q),
    .status_o       (status_o),
    .entropy_x_o    (entropy_x_o),
    .cond_entropy_o (cond_entropy_o),
    .mutual_info_o  (mutual_info_o),
    .sample_total_o (sample_total_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while the previous one was in progress");

  a_zero_values_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (entropy_x_o == 24'd0) && (cond_entropy_o == 24'd0) && (mutual_info_o == 25'sd0))
    else $error("nonzero estimate with an error status");

  a_empty_has_no_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> sample_total_o == 24'd0)
    else $error("empty report with a nonzero total");
endmodule

FILE: src/jhmi_log2.sv
// Serial truncated base-2 logarithm: leading-one search, then one squaring round per cycle.
`timescale 1ns / 1ps
module jhmi_log2 #(
  parameter int CB = 24,
  parameter int F  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [CB-1:0]                value_i,
  output logic                         done_o,
  output logic [$clog2(CB)+F-1:0]      log_o
);
  localparam int PW = $clog2(CB);
  localparam int KW = $clog2(F);
  localparam int MW = F + 1;

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_e;

  lstate_e       state_q;
  logic [CB-1:0] w_q;
  logic [PW-1:0] p_q;
  logic [MW-1:0] m_q;
  logic [F-1:0]  frac_q;
  logic [KW-1:0] k_q;
  logic          done_q;

  logic [CB+F-1:0] ext;
  logic [MW-1:0]   m_init;
  logic [2*MW-1:0] sq;
  logic [F+1:0]    t;
  logic            big;
  logic [MW-1:0]   m_next;

  assign ext    = {w_q, F'(0)};
  assign m_init = ext[CB+F-1 -: MW];
  assign sq     = (2*MW)'(m_q) * (2*MW)'(m_q);
  assign t      = sq[F +: F+2];
  assign big    = t[F+1];
  assign m_next = big ? t[F+1:1] : t[F:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            w_q     <= value_i;
            p_q     <= PW'(CB - 1);
            frac_q  <= '0;
            k_q     <= KW'(F - 1);
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (w_q[CB-1]) begin
            m_q     <= m_init;
            state_q <= L_SQ;
          end else begin
            w_q <= w_q << 1;
            p_q <= p_q - PW'(1);
          end
        end
        L_SQ: begin
          m_q <= m_next;
          if (big) frac_q[k_q] <= 1'b1;
          if (k_q == '0) begin
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end else begin
            k_q <= k_q - KW'(1);
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign log_o  = {p_q, frac_q};
endmodule

FILE: src/jhmi_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module jhmi_div #(
  parameter int NW = 45,
  parameter int DW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [DW:0] rem_sh;
  logic [DW:0] diff;
  logic        ge;

  assign rem_sh = {rem_q, q_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign diff   = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        q_q    <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
        cnt_q  <= CW'(NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        q_q   <= {q_q[NW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

FILE: src/jhmi_datapath.sv
// Histogram memories, entry scan, accumulators, log and divide units and result register.
`timescale 1ns / 1ps
module jhmi_datapath #(
  parameter int NUM_X      = 16,
  parameter int NUM_Y      = 16,
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jhmi_pkg::cmd_t      cmd_i,
  output jhmi_pkg::stat_t     stat_o,
  input  logic [1:0]          req_type_i,
  input  logic [3:0]          sample_x_i,
  input  logic [3:0]          sample_y_i,
  input  logic [4:0]          x_symbols_i,
  input  logic [4:0]          y_symbols_i,
  output logic [1:0]          status_o,
  output logic [23:0]         entropy_x_o,
  output logic [23:0]         cond_entropy_o,
  output logic signed [24:0]  mutual_info_o,
  output logic [23:0]         sample_total_o
);
  import jhmi_pkg::*;

  localparam int CB  = COUNT_BITS;
  localparam int XW  = $clog2(NUM_X);
  localparam int YW  = $clog2(NUM_Y);
  localparam int PD  = NUM_X * NUM_Y;
  localparam int PAW = $clog2(PD);
  localparam int PW  = $clog2(CB);
  localparam int LW  = PW + FRAC_BITS;
  localparam int AW  = CB + LW;
  localparam logic signed [65:0] MI_MAX = 66'sd16777215;
  localparam logic signed [65:0] MI_MIN = -66'sd16777216;

  typedef enum logic [1:0] {GRP_ROW, GRP_COL, GRP_PAIR} grp_e;

  req_e          req_q;
  logic [3:0]    x_q, y_q;
  logic          range_q, sat_q, empty_q;
  logic [CB-1:0] total_q;
  logic [PAW-1:0] clr_q;

  logic [CB-1:0] pair_mem [PD];
  logic [CB-1:0] row_mem  [NUM_X];
  logic [CB-1:0] col_mem  [NUM_Y];
  logic [CB-1:0] pair_rd_q, row_rd_q, col_rd_q;

  logic           scan_q;
  logic [PAW-1:0] idx_q;
  grp_e           grp_q;
  logic [AW-1:0]  acc_row_q, acc_col_q, acc_pair_q;
  logic [CB-1:0]  val_q;
  logic [AW-1:0]  prod_q;
  logic [LW-1:0]  ls_q;
  logic [AW-1:0]  q0_q, hc_q;

  logic [1:0]  status_q;
  logic [23:0] hx_out_q, hc_out_q, tot_out_q;
  logic [24:0] mi_out_q;

  logic [XW-1:0]  cap_row, row_ra;
  logic [YW-1:0]  cap_col, col_ra;
  logic [PAW-1:0] cap_pair, pair_ra;
  logic [CB-1:0]  scan_val, log_in;
  logic [PAW-1:0] size_m1;
  logic           grp_end;
  logic [LW-1:0]  log_val;
  logic           log_done;
  logic [AW-1:0]  hc_num, div_num, quot, hx;
  logic           div_done;
  logic           range_ok;

  assign cap_row  = XW'(x_q);
  assign cap_col  = YW'(y_q);
  assign cap_pair = PAW'(cap_row) * PAW'(NUM_Y) + PAW'(cap_col);
  assign row_ra   = scan_q ? idx_q[XW-1:0] : cap_row;
  assign col_ra   = scan_q ? idx_q[YW-1:0] : cap_col;
  assign pair_ra  = scan_q ? idx_q : cap_pair;

  assign range_ok = (5'({1'b0, sample_x_i}) < x_symbols_i) && (32'(sample_x_i) < 32'(NUM_X))
                 && (5'({1'b0, sample_y_i}) < y_symbols_i) && (32'(sample_y_i) < 32'(NUM_Y));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      pair_mem[clr_q] <= '0;
    end else if (cmd_i.cnt_wr) begin
      pair_mem[cap_pair] <= pair_rd_q + CB'(1);
    end
    pair_rd_q <= pair_mem[pair_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      if (clr_q < PAW'(NUM_X)) row_mem[clr_q[XW-1:0]] <= '0;
    end else if (cmd_i.cnt_wr) begin
      row_mem[cap_row] <= row_rd_q + CB'(1);
    end
    row_rd_q <= row_mem[row_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      if (clr_q < PAW'(NUM_Y)) col_mem[clr_q[YW-1:0]] <= '0;
    end else if (cmd_i.cnt_wr) begin
      col_mem[cap_col] <= col_rd_q + CB'(1);
    end
    col_rd_q <= col_mem[col_ra];
  end

  always_comb begin
    case (grp_q)
      GRP_ROW: begin
        scan_val = row_rd_q;
        size_m1  = PAW'(NUM_X - 1);
      end
      GRP_COL: begin
        scan_val = col_rd_q;
        size_m1  = PAW'(NUM_Y - 1);
      end
      default: begin
        scan_val = pair_rd_q;
        size_m1  = PAW'(PD - 1);
      end
    endcase
  end

  assign grp_end = idx_q == size_m1;
  assign log_in  = cmd_i.log_tot ? total_q : scan_val;
  assign hc_num  = (acc_col_q > acc_pair_q) ? acc_col_q - acc_pair_q : '0;
  assign div_num = cmd_i.div_sel ? hc_num : acc_row_q;
  assign hx      = (AW'(ls_q) > q0_q) ? AW'(ls_q) - q0_q : '0;

  jhmi_log2 #(.CB(CB), .F(FRAC_BITS)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .value_i (log_in),
    .done_o  (log_done),
    .log_o   (log_val)
  );

  jhmi_div #(.NW(AW), .DW(CB)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      clr_q   <= '0;
      scan_q  <= 1'b0;
      idx_q   <= '0;
      grp_q   <= GRP_ROW;
    end else begin
      if (cmd_i.capture) scan_q <= 1'b0;
      if (cmd_i.clr_start) total_q <= '0;
      if (cmd_i.cnt_wr) total_q <= total_q + CB'(1);
      if (cmd_i.clr_step) begin
        clr_q <= (clr_q == PAW'(PD - 1)) ? '0 : clr_q + PAW'(1);
      end
      if (cmd_i.scan_start) begin
        scan_q <= 1'b1;
        idx_q  <= '0;
        grp_q  <= GRP_ROW;
      end else if (cmd_i.scan_next) begin
        if (grp_end) begin
          idx_q <= '0;
          grp_q <= (grp_q == GRP_ROW) ? GRP_COL : GRP_PAIR;
        end else begin
          idx_q <= idx_q + PAW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_e'(req_type_i);
      x_q     <= sample_x_i;
      y_q     <= sample_y_i;
      range_q <= range_ok;
      sat_q   <= total_q == '1;
      empty_q <= total_q == '0;
    end
    if (cmd_i.scan_start) begin
      acc_row_q  <= '0;
      acc_col_q  <= '0;
      acc_pair_q <= '0;
    end
    if (cmd_i.log_start) val_q <= scan_val;
    if (cmd_i.mul) prod_q <= AW'(val_q) * AW'(log_val);
    if (cmd_i.acc) begin
      case (grp_q)
        GRP_ROW: acc_row_q  <= acc_row_q + prod_q;
        GRP_COL: acc_col_q  <= acc_col_q + prod_q;
        default: acc_pair_q <= acc_pair_q + prod_q;
      endcase
    end
    if (cmd_i.ls_take) ls_q <= log_val;
    if (cmd_i.take_q0) q0_q <= quot;
    if (cmd_i.take_hc) hc_q <= quot;
  end

  logic               ok_rep;
  logic [63:0]        hx64, hc64;
  logic signed [65:0] mi_full;
  logic [31:0]        tot32;
  status_e            st_code;

  assign ok_rep  = (req_q == REQ_REPORT) && !empty_q;
  assign hx64    = 64'(hx);
  assign hc64    = 64'(hc_q);
  assign mi_full = $signed({2'b00, hx64}) - $signed({2'b00, hc64});
  assign tot32   = 32'(total_q);

  always_comb begin
    case (req_q)
      REQ_COUNT:  st_code = !range_q ? ST_RANGE : (sat_q ? ST_SAT : ST_OK);
      REQ_REPORT: st_code = empty_q ? ST_EMPTY : ST_OK;
      default:    st_code = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q  <= st_code;
      tot_out_q <= tot32[23:0];
      if (ok_rep) begin
        hx_out_q <= (hx64 > 64'hFFFFFF) ? 24'hFFFFFF : hx64[23:0];
        hc_out_q <= (hc64 > 64'hFFFFFF) ? 24'hFFFFFF : hc64[23:0];
        if (mi_full > MI_MAX) mi_out_q <= 25'h0FFFFFF;
        else if (mi_full < MI_MIN) mi_out_q <= 25'h1000000;
        else mi_out_q <= mi_full[24:0];
      end else begin
        hx_out_q <= '0;
        hc_out_q <= '0;
        mi_out_q <= '0;
      end
    end
  end

  assign stat_o.req       = req_q;
  assign stat_o.range_ok  = range_q;
  assign stat_o.sat       = sat_q;
  assign stat_o.empty     = empty_q;
  assign stat_o.clr_last  = clr_q == PAW'(PD - 1);
  assign stat_o.scan_last = grp_end && (grp_q == GRP_PAIR);
  assign stat_o.scan_zero = scan_val == '0;
  assign stat_o.log_done  = log_done;
  assign stat_o.div_done  = div_done;

  assign status_o       = status_q;
  assign entropy_x_o    = hx_out_q;
  assign cond_entropy_o = hc_out_q;
  assign mutual_info_o  = $signed(mi_out_q);
  assign sample_total_o = tot_out_q;
endmodule

FILE: src/jhmi_ctrl.sv
// Controller state machine that sequences counting, clearing and report computation.
`timescale 1ns / 1ps
module jhmi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  jhmi_pkg::stat_t stat_i,
  output jhmi_pkg::cmd_t  cmd_o
);
  import jhmi_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_CNT_WR, S_CLR, S_SCAN_RD, S_SCAN_CHK, S_LOG,
    S_MUL, S_ACC, S_LOGS_ST, S_LOGS, S_DIV1, S_DIV2, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_INIT:     cmd_o.clr_step = 1'b1;
      S_IDLE:     cmd_o.capture = in_valid_i;
      S_DISP: begin
        cmd_o.scan_start = (stat_i.req == REQ_REPORT) && !stat_i.empty;
        cmd_o.clr_start  = stat_i.req == REQ_CLEAR;
      end
      S_CNT_WR:   cmd_o.cnt_wr = 1'b1;
      S_CLR:      cmd_o.clr_step = 1'b1;
      S_SCAN_RD:  ;
      S_SCAN_CHK: begin
        cmd_o.log_start = !stat_i.scan_zero;
        cmd_o.scan_next = stat_i.scan_zero && !stat_i.scan_last;
      end
      S_LOG:      ;
      S_MUL:      cmd_o.mul = 1'b1;
      S_ACC: begin
        cmd_o.acc       = 1'b1;
        cmd_o.scan_next = !stat_i.scan_last;
      end
      S_LOGS_ST: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_tot   = 1'b1;
      end
      S_LOGS: begin
        cmd_o.ls_take   = stat_i.log_done;
        cmd_o.div_start = stat_i.log_done;
      end
      S_DIV1: begin
        cmd_o.take_q0   = stat_i.div_done;
        cmd_o.div_start = stat_i.div_done;
        cmd_o.div_sel   = 1'b1;
      end
      S_DIV2:     cmd_o.take_hc = stat_i.div_done;
      S_OUT:      cmd_o.out_load = out_free;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_INIT:     if (stat_i.clr_last) state_q <= S_IDLE;
        S_IDLE:     if (in_valid_i) state_q <= S_DISP;
        S_DISP: begin
          unique case (stat_i.req)
            REQ_COUNT:  state_q <= (stat_i.range_ok && !stat_i.sat) ? S_CNT_WR : S_OUT;
            REQ_REPORT: state_q <= stat_i.empty ? S_OUT : S_SCAN_RD;
            REQ_CLEAR:  state_q <= S_CLR;
            default:    state_q <= S_OUT;
          endcase
        end
        S_CNT_WR:   state_q <= S_OUT;
        S_CLR:      if (stat_i.clr_last) state_q <= S_OUT;
        S_SCAN_RD:  state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (!stat_i.scan_zero) state_q <= S_LOG;
          else if (stat_i.scan_last) state_q <= S_LOGS_ST;
          else state_q <= S_SCAN_RD;
        end
        S_LOG:      if (stat_i.log_done) state_q <= S_MUL;
        S_MUL:      state_q <= S_ACC;
        S_ACC:      state_q <= stat_i.scan_last ? S_LOGS_ST : S_SCAN_RD;
        S_LOGS_ST:  state_q <= S_LOGS;
        S_LOGS:     if (stat_i.log_done) state_q <= S_DIV1;
        S_DIV1:     if (stat_i.div_done) state_q <= S_DIV2;
        S_DIV2:     if (stat_i.div_done) state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
endmodule
